[sv/tgad_pkg.sv]
package tgad_pkg;

   // result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_TYPE = 2'd1;
   localparam logic [1:0] STAT_BAD_BPP  = 2'd2;
   localparam logic [1:0] STAT_CLIPPED  = 2'd3;

   // input word: one file byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   // result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
      logic [7:0]  run_length;
      logic        last_run;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
   } rsp_type;

endpackage

[sv/tgad_parser.sv]
module tgad_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  tgad_pkg::req_type in_word,
   output logic             res_valid,
   output tgad_pkg::rsp_type res_word
);
   import tgad_pkg::*;

   // parser phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_IDSKIP = 3'd1;
   localparam logic [2:0] PH_PACKET = 3'd2;
   localparam logic [2:0] PH_PIXEL  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_ERROR  = 3'd5;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // accepted header values
   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  header_index_ff, header_index_in;
   logic [7:0]  id_skip_left_ff, id_skip_left_in;
   logic        is_rle_ff, is_rle_in;
   logic        four_bytes_ff, four_bytes_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_repeat_ff, packet_repeat_in;
   logic [1:0]  color_index_ff, color_index_in;
   logic [31:0] color_hold_ff, color_hold_in;

   logic [2:0]  phase_cur;
   logic [4:0]  hidx_cur;
   logic [7:0]  b;
   logic [31:0] hold_new;
   logic        last_byte;
   logic [7:0]  run;
   logic        clipped;
   logic [7:0]  pkt_next;
   logic [31:0] pix_next;

   // next state and result for one byte
   always_comb begin
      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      id_skip_left_in  = id_skip_left_ff;
      is_rle_in        = is_rle_ff;
      four_bytes_in    = four_bytes_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      pixels_left_in   = pixels_left_ff;
      packet_left_in   = packet_left_ff;
      packet_repeat_in = packet_repeat_ff;
      color_index_in   = color_index_ff;
      color_hold_in    = color_hold_ff;
      res_valid        = 1'b0;
      res_word         = '0;
      hold_new         = color_hold_ff;
      last_byte        = 1'b0;
      run              = 8'd1;
      clipped          = 1'b0;
      pkt_next         = packet_left_ff;
      pix_next         = pixels_left_ff;
      b                = in_word.data_byte;

      // start of file restarts the header parse
      phase_cur = in_word.start_of_file ? PH_HEADER : phase_ff;
      hidx_cur  = in_word.start_of_file ? HDR_ID_LEN : header_index_ff;
      phase_in        = phase_cur;
      header_index_in = hidx_cur;

      unique case (phase_cur)
         PH_HEADER: begin
            case (hidx_cur)
               HDR_ID_LEN:    id_skip_left_in = b;
               HDR_IMG_TYPE: begin
                  if (b != TYPE_RAW && b != TYPE_RLE) begin
                     res_valid       = 1'b1;
                     res_word.kind   = KIND_ERROR;
                     res_word.status = STAT_BAD_TYPE;
                     phase_in        = PH_ERROR;
                  end
                  is_rle_in = (b == TYPE_RLE);
               end
               HDR_WIDTH_LO:  width_in[7:0]   = b;
               HDR_WIDTH_HI:  width_in[15:8]  = b;
               HDR_HEIGHT_LO: height_in[7:0]  = b;
               HDR_HEIGHT_HI: height_in[15:8] = b;
               HDR_DEPTH: begin
                  if (b == DEPTH_24) begin
                     four_bytes_in = 1'b0;
                  end else if (b == DEPTH_32) begin
                     four_bytes_in = 1'b1;
                  end else begin
                     res_valid       = 1'b1;
                     res_word.kind   = KIND_ERROR;
                     res_word.status = STAT_BAD_BPP;
                     phase_in        = PH_ERROR;
                  end
               end
               default: ;
            endcase
            if (res_valid) begin
               // error: keep the old type flag, parse stops here
               is_rle_in       = is_rle_ff;
               header_index_in = hidx_cur;
            end else if (hidx_cur != HDR_LAST) begin
               header_index_in = hidx_cur + 5'd1;
            end else begin
               // header complete
               header_index_in       = HDR_ID_LEN;
               pixels_left_in        = {16'd0, width_ff} * {16'd0, height_ff};
               res_valid             = 1'b1;
               res_word.kind         = KIND_HEADER;
               res_word.status       = STAT_OK;
               res_word.image_width  = width_ff;
               res_word.image_height = height_ff;
               res_word.has_alpha    = four_bytes_ff;
               if (id_skip_left_ff != 8'd0) begin
                  phase_in = PH_IDSKIP;
               end else begin
                  color_index_in   = 2'd0;
                  color_hold_in    = '0;
                  packet_left_in   = 8'd0;
                  packet_repeat_in = 1'b0;
                  if (width_ff == 16'd0 || height_ff == 16'd0)
                     phase_in = PH_DONE;
                  else if (is_rle_ff)
                     phase_in = PH_PACKET;
                  else
                     phase_in = PH_PIXEL;
               end
            end
         end

         PH_IDSKIP: begin
            id_skip_left_in = id_skip_left_ff - 8'd1;
            if (id_skip_left_ff == 8'd1) begin
               color_index_in   = 2'd0;
               color_hold_in    = '0;
               packet_left_in   = 8'd0;
               packet_repeat_in = 1'b0;
               if (pixels_left_ff == 32'd0)
                  phase_in = PH_DONE;
               else if (is_rle_ff)
                  phase_in = PH_PACKET;
               else
                  phase_in = PH_PIXEL;
            end
         end

         PH_PACKET: begin
            // packet byte: top bit selects repeat, low bits the count minus one
            packet_repeat_in = b[7];
            packet_left_in   = {1'b0, b[6:0]} + 8'd1;
            color_index_in   = 2'd0;
            color_hold_in    = '0;
            phase_in         = PH_PIXEL;
         end

         PH_PIXEL: begin
            // gather the pixel bytes in blue, green, red, alpha order
            case (color_index_ff)
               2'd0:    hold_new[7:0]   = color_hold_ff[7:0]   | b;
               2'd1:    hold_new[15:8]  = color_hold_ff[15:8]  | b;
               2'd2:    hold_new[23:16] = color_hold_ff[23:16] | b;
               default: hold_new[31:24] = color_hold_ff[31:24] | b;
            endcase
            last_byte = (color_index_ff == 2'd3) ||
                        (!four_bytes_ff && color_index_ff == 2'd2);
            if (!last_byte) begin
               color_index_in = color_index_ff + 2'd1;
               color_hold_in  = hold_new;
            end else begin
               color_index_in = 2'd0;
               color_hold_in  = '0;
               // run length, clipped to the pixels that remain
               if (is_rle_ff && packet_repeat_ff) begin
                  run = packet_left_ff;
                  if ({24'd0, packet_left_ff} > pixels_left_ff) begin
                     run     = pixels_left_ff[7:0];
                     clipped = 1'b1;
                  end
                  pkt_next = 8'd0;
               end else begin
                  run = 8'd1;
                  if (is_rle_ff)
                     pkt_next = packet_left_ff - 8'd1;
               end
               pix_next       = pixels_left_ff - {24'd0, run};
               pixels_left_in = pix_next;
               packet_left_in = pkt_next;
               if (pix_next == 32'd0) begin
                  if (is_rle_ff && pkt_next != 8'd0)
                     clipped = 1'b1;
                  packet_left_in = 8'd0;
                  phase_in       = PH_DONE;
               end else if (is_rle_ff && pkt_next == 8'd0) begin
                  phase_in = PH_PACKET;
               end
               res_valid           = 1'b1;
               res_word.kind       = KIND_PIXEL;
               res_word.status     = clipped ? STAT_CLIPPED : STAT_OK;
               res_word.blue       = hold_new[7:0];
               res_word.green      = hold_new[15:8];
               res_word.red        = hold_new[23:16];
               res_word.alpha      = four_bytes_ff ? hold_new[31:24] : 8'd0;
               res_word.run_length = run;
               res_word.last_run   = (pix_next == 32'd0);
            end
         end

         default: ;
      endcase

      if (!step)
         res_valid = 1'b0;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_index_ff  <= HDR_ID_LEN;
         id_skip_left_ff  <= 8'd0;
         is_rle_ff        <= 1'b0;
         four_bytes_ff    <= 1'b0;
         width_ff         <= 16'd0;
         height_ff        <= 16'd0;
         pixels_left_ff   <= 32'd0;
         packet_left_ff   <= 8'd0;
         packet_repeat_ff <= 1'b0;
         color_index_ff   <= 2'd0;
         color_hold_ff    <= 32'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         id_skip_left_ff  <= id_skip_left_in;
         is_rle_ff        <= is_rle_in;
         four_bytes_ff    <= four_bytes_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_repeat_ff <= packet_repeat_in;
         color_index_ff   <= color_index_in;
         color_hold_ff    <= color_hold_in;
      end
   end

endmodule

[sv/tga_rle_pixel_decoder_core.sv]
// TGA stream decoder for uncompressed (type 2) and run-length (type 10)
// true-color images at 24 or 32 bits per pixel.
// Input channel (req_): one file byte per word; start_of_file marks byte 0
// of a new file and restarts the header parse from any phase.
// Result channel (rsp_): at most one word per input byte: a header word
// (size, alpha) at header byte 17, an error word at a bad type or depth
// byte, or a pixel run word when the last byte of a pixel arrives.
// Each byte is captured in the input register; the parser step then moves
// its result from the input register into the result register.
// Throughput: one byte per cycle while rsp_stall does not hold a result;
// a new byte is taken while a result still waits to be taken.
// When rsp_stall holds a pending result, the input register holds too and
// req_stall rises once it is full; nothing is dropped or repeated.
// Reset (synchronous) empties both registers and returns the parser to
// header byte 0.
module tga_rle_pixel_decoder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tgad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tgad_pkg::rsp_type rsp_data
);
   import tgad_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    out_free;
   logic    advance;
   logic    res_valid;
   rsp_type res_word;

   // flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      if (req_valid && !req_stall)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;
      out_valid_in = out_free ? (advance && res_valid) : out_valid_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
      if (req_valid && !req_stall)
         in_data_ff <= req_data;
   end

   tgad_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_word   (in_data_ff),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
      if (advance && res_valid)
         out_data_ff <= res_word;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
